@@ rtl/assert_macros.svh @@
// Assertion macros shared by the binarizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/lab_pkg.sv @@
// Types and constants shared by the local adaptive binarizer modules.
package lab_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DYN_RANGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_W     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_H     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_W     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_H     = 3'd6;

  // Threshold rules.
  localparam logic [1:0] MODE_NIBLACK = 2'd0;
  localparam logic [1:0] MODE_SAUVOLA = 2'd1;
  localparam logic [1:0] MODE_WOLF    = 2'd2;

  // Command codes.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [7:0] GRAY_MAX = 8'd255;

  // Statistic widths: Q8.8 mean and deviation, radicand of the deviation.
  localparam int DEV_W = 16;
  localparam int RAD_W = 32;

  typedef struct packed {
    logic       func;
    logic [7:0] pixel;
  } lab_cmd_t;

  typedef struct packed {
    logic white;
    logic last;
  } lab_result_t;

  // Per-pixel threshold request from the controller to the threshold pipe.
  typedef struct packed {
    logic [1:0]       mode;
    logic [15:0]      k_gain;
    logic [15:0]      range_q;
    logic [DEV_W-1:0] max_dev;
    logic [7:0]       min_pixel;
    logic             force_white;
    logic             force_black;
  } lab_thr_req_t;

endpackage

@@ rtl/local_adaptive_binarizer_core.sv @@
// Top level of the local adaptive binarizer: frame and statistic memories and control.
//
//  Channel  | Ports                              | Beat taken when
//  ---------+------------------------------------+-------------------------
//  command  | start, busy, cmd                   | start high, busy low
//  result   | done, result                       | done high (one cycle)
//  config   | cfg_we, cfg_index, cfg_data        | cfg_we high
//
// After the final pixel the statistics pass runs with busy high; its pace per window
// centre is set by the single frame memory read port and the shared divider and
// square root units. A read beat raises its result strobe after the frame and
// statistic memory reads and the three-stage threshold pipe; busy stays high until
// the strobe cycle ends. Reset is synchronous and returns to loading with default
// registers; memories are not cleared. Results cannot be held off.
`include "assert_macros.svh"

module local_adaptive_binarizer_core #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_WIN    = 31
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  lab_pkg::lab_cmd_t                  cmd,
  output logic                               busy,
  output logic                               done,
  output lab_pkg::lab_result_t               result,
  input  logic                               cfg_we,
  input  logic [lab_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lab_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);
  localparam int XW      = $clog2(MAX_WIDTH + 1);
  localparam int YW      = $clog2(MAX_HEIGHT + 1);
  localparam int WW      = $clog2(MAX_WIN + 1);
  localparam int AREA_W  = $clog2(MAX_WIN * MAX_WIN + 1);
  localparam int SUM_W   = AREA_W + 8;
  localparam int SQ_W    = AREA_W + 16;
  localparam int NUM_W   = AREA_W + SQ_W;
  localparam int DVD_W   = NUM_W + 16;
  localparam int DVS_W   = 2 * AREA_W;
  localparam int WIN_TOP = (MAX_WIN - 1) | 1;
  localparam int DW      = lab_pkg::DEV_W;

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_SINIT  = 4'd1;
  localparam logic [3:0] ST_CINIT  = 4'd2;
  localparam logic [3:0] ST_WIN    = 4'd3;
  localparam logic [3:0] ST_WDRAIN = 4'd4;
  localparam logic [3:0] ST_MUL    = 4'd5;
  localparam logic [3:0] ST_SUB    = 4'd6;
  localparam logic [3:0] ST_DIV1   = 4'd7;
  localparam logic [3:0] ST_DIV2   = 4'd8;
  localparam logic [3:0] ST_SQRT   = 4'd9;
  localparam logic [3:0] ST_READ   = 4'd10;
  localparam logic [3:0] ST_RD1    = 4'd11;
  localparam logic [3:0] ST_RD2    = 4'd12;
  localparam logic [3:0] ST_RWAIT  = 4'd13;

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [15:0] k_r;
  logic [15:0] rng_r;
  logic [4:0]  winw_r;
  logic [4:0]  winh_r;
  logic [7:0]  imgw_r;
  logic [7:0]  imgh_r;

  // Control state.
  logic [3:0]       state;
  logic [AW:0]      ld_idx;
  logic [AW:0]      ld_next;
  logic [AW:0]      rd_idx;
  logic [XW-1:0]    rx;
  logic [YW-1:0]    ry;
  logic             last_r;
  logic [DW-1:0]    max_dev;
  logic [7:0]       min_pix;
  logic             accept;

  // Live frame geometry.
  logic [XW-1:0]    w;
  logic [YW-1:0]    h;
  logic [WW-1:0]    ww;
  logic [WW-1:0]    wh;
  logic [4:0]       ww_odd;
  logic [4:0]       wh_odd;
  logic [AW:0]      size;
  logic             frame_small;
  logic [AREA_W-1:0] area_c;

  // Statistics pass registers.
  logic [XW-1:0]    sw;
  logic [YW-1:0]    sh;
  logic [WW-1:0]    sww;
  logic [WW-1:0]    swh;
  logic [AREA_W-1:0] area;
  logic [DVS_W-1:0] area_sq;
  logic [AW-1:0]    coff;
  logic [XW-1:0]    cxo;
  logic [YW-1:0]    cyo;
  logic [AW-1:0]    wbase;
  logic [AW-1:0]    rstart;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    rowaddr;
  logic [WW-1:0]    wx;
  logic [WW-1:0]    wy;
  logic             acc_v;
  logic [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sq;
  logic [NUM_W-1:0] prod_a;
  logic [NUM_W-1:0] prod_b;
  logic [NUM_W-1:0] num;
  logic [DW-1:0]    mean_r;
  logic             more_x;
  logic             more_y;

  // Memories and their ports.
  logic [7:0]       fs_mem [DEPTH];
  logic             fs_we;
  logic [AW-1:0]    fs_raddr;
  logic [7:0]       fs_q;
  logic [2*DW-1:0]  st_mem [DEPTH];
  logic             st_we;
  logic [AW-1:0]    st_waddr;
  logic [AW-1:0]    st_raddr;
  logic [2*DW-1:0]  st_q;

  // Shared arithmetic units.
  logic                       div_start;
  logic [DVD_W-1:0]           div_dvd;
  logic [DVS_W-1:0]           div_dvs;
  logic                       div_done;
  logic [lab_pkg::RAD_W-1:0]  div_q;
  logic                       sq_start;
  logic                       sq_done;
  logic [DW-1:0]              sq_root;
  logic                       thr_start;
  lab_pkg::lab_thr_req_t      thr_req;
  logic                       thr_done;
  logic                       thr_white;

  // Read-out window centre.
  logic [31:0]      xc;
  logic [31:0]      yc;
  logic [31:0]      xhi;
  logic [31:0]      yhi;

  // Geometry with saturation of sizes and odd windows.
  always_comb begin
    if (imgw_r == 8'd0) begin
      w = XW'(1);
    end else if (32'(imgw_r) > MAX_WIDTH) begin
      w = XW'(MAX_WIDTH);
    end else begin
      w = XW'(imgw_r);
    end
    if (imgh_r == 8'd0) begin
      h = YW'(1);
    end else if (32'(imgh_r) > MAX_HEIGHT) begin
      h = YW'(MAX_HEIGHT);
    end else begin
      h = YW'(imgh_r);
    end
    ww_odd = winw_r | 5'd1;
    wh_odd = winh_r | 5'd1;
    ww = (32'(ww_odd) > MAX_WIN) ? WW'(WIN_TOP) : WW'(ww_odd);
    wh = (32'(wh_odd) > MAX_WIN) ? WW'(WIN_TOP) : WW'(wh_odd);
    size        = (AW+1)'(w * h);
    frame_small = (32'(w) < 32'(ww)) || (32'(h) < 32'(wh));
    area_c      = AREA_W'(ww * wh);
  end

  assign accept  = start && !busy;
  assign busy    = (state != ST_LOAD) && (state != ST_READ);
  assign fs_we   = accept && (cmd.func == lab_pkg::FUNC_LOAD) && (state == ST_LOAD) &&
                   (ld_idx < size);
  assign ld_next = fs_we ? ld_idx + (AW+1)'(1) : ld_idx;

  assign more_x = (32'(cxo) + 32'(sww)) < 32'(sw);
  assign more_y = (32'(cyo) + 32'(swh)) < 32'(sh);

  // Clamp the read position into the range of valid window centres.
  always_comb begin
    xhi = 32'(w) - 32'd1 - 32'(ww >> 1);
    yhi = 32'(h) - 32'd1 - 32'(wh >> 1);
    if (32'(rx) < 32'(ww >> 1)) begin
      xc = 32'(ww >> 1);
    end else if (32'(rx) > xhi) begin
      xc = xhi;
    end else begin
      xc = 32'(rx);
    end
    if (32'(ry) < 32'(wh >> 1)) begin
      yc = 32'(wh >> 1);
    end else if (32'(ry) > yhi) begin
      yc = yhi;
    end else begin
      yc = 32'(ry);
    end
  end

  // Memory port selection.
  assign fs_raddr = (state == ST_RD1) ? rd_idx[AW-1:0] : raddr;
  assign st_raddr = AW'(yc * 32'(w) + xc);
  assign st_we    = (state == ST_SQRT) && sq_done;
  assign st_waddr = wbase + coff;

  // Frame store: load writes, window walk and read-out read.
  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[ld_idx[AW-1:0]] <= cmd.pixel;
    end
    fs_q <= fs_mem[fs_raddr];
  end

  // Statistic map: mean in the upper half, deviation in the lower half.
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= {mean_r, sq_root};
    end
    st_q <= st_mem[st_raddr];
  end

  // Divider serves the mean first and the variance second.
  assign div_start = (state == ST_SUB) || ((state == ST_DIV1) && div_done);
  assign div_dvd   = (state == ST_SUB) ? DVD_W'({sum, 8'h00}) : {num, 16'h0000};
  assign div_dvs   = (state == ST_SUB) ? DVS_W'(area) : area_sq;
  assign sq_start  = (state == ST_DIV2) && div_done;

  lab_divider #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W),
    .Q_W   (lab_pkg::RAD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  lab_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (div_q),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Threshold request for the pixel being read.
  always_comb begin
    thr_req.mode        = mode_r;
    thr_req.k_gain      = k_r;
    thr_req.range_q     = (rng_r == 16'd0) ? 16'd1 : rng_r;
    thr_req.max_dev     = max_dev;
    thr_req.min_pixel   = min_pix;
    thr_req.force_white = frame_small;
    thr_req.force_black = (mode_r == lab_pkg::MODE_WOLF) && (max_dev == '0);
  end

  assign thr_start = (state == ST_RD2);

  lab_thresh u_thr (
    .clk   (clk),
    .rst   (rst),
    .start (thr_start),
    .req   (thr_req),
    .pix   (fs_q),
    .mean  (st_q[2*DW-1:DW]),
    .dev   (st_q[DW-1:0]),
    .done  (thr_done),
    .white (thr_white)
  );

  assign done         = thr_done;
  assign result.white = thr_white;
  assign result.last  = last_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= lab_pkg::MODE_SAUVOLA;
      k_r    <= 16'd2048;
      rng_r  <= 16'd32768;
      winw_r <= 5'd15;
      winh_r <= 5'd15;
      imgw_r <= 8'd128;
      imgh_r <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lab_pkg::CFG_MODE:      mode_r <= cfg_data[1:0];
        lab_pkg::CFG_K_GAIN:    k_r    <= cfg_data;
        lab_pkg::CFG_DYN_RANGE: rng_r  <= cfg_data;
        lab_pkg::CFG_WIN_W:     winw_r <= cfg_data[4:0];
        lab_pkg::CFG_WIN_H:     winh_r <= cfg_data[4:0];
        lab_pkg::CFG_IMG_W:     imgw_r <= cfg_data[7:0];
        lab_pkg::CFG_IMG_H:     imgh_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Window accumulation on the registered frame store read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_v <= 1'b0;
    end else begin
      acc_v <= (state == ST_WIN);
    end
    if (state == ST_CINIT) begin
      sum <= '0;
      sq  <= '0;
    end else if (acc_v) begin
      sum <= sum + SUM_W'(fs_q);
      sq  <= sq + SQ_W'(fs_q * fs_q);
    end
  end

  // Main sequencer: load, statistics pass, read-out.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      ld_idx  <= '0;
      rd_idx  <= '0;
      rx      <= '0;
      ry      <= '0;
      max_dev <= '0;
      min_pix <= lab_pkg::GRAY_MAX;
      last_r  <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (accept && (cmd.func == lab_pkg::FUNC_LOAD)) begin
            ld_idx <= ld_next;
            if (fs_we && (cmd.pixel < min_pix)) begin
              min_pix <= cmd.pixel;
            end
            if (ld_next >= size) begin
              state <= ST_SINIT;
            end
          end
        end
        ST_SINIT: begin
          sw      <= w;
          sh      <= h;
          sww     <= ww;
          swh     <= wh;
          area    <= area_c;
          area_sq <= DVS_W'(area_c * area_c);
          coff    <= AW'(32'(wh >> 1) * 32'(w) + 32'(ww >> 1));
          cxo     <= '0;
          cyo     <= '0;
          wbase   <= '0;
          rstart  <= '0;
          max_dev <= '0;
          rd_idx  <= '0;
          rx      <= '0;
          ry      <= '0;
          state   <= frame_small ? ST_READ : ST_CINIT;
        end
        ST_CINIT: begin
          raddr   <= wbase;
          rowaddr <= wbase;
          wx      <= '0;
          wy      <= '0;
          state   <= ST_WIN;
        end
        ST_WIN: begin
          if (wx == sww - WW'(1)) begin
            wx <= '0;
            if (wy == swh - WW'(1)) begin
              state <= ST_WDRAIN;
            end else begin
              wy      <= wy + WW'(1);
              rowaddr <= rowaddr + AW'(sw);
              raddr   <= rowaddr + AW'(sw);
            end
          end else begin
            wx    <= wx + WW'(1);
            raddr <= raddr + AW'(1);
          end
        end
        ST_WDRAIN: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod_a <= NUM_W'(area * sq);
          prod_b <= NUM_W'(sum * sum);
          state  <= ST_SUB;
        end
        ST_SUB: begin
          num   <= prod_a - prod_b;
          state <= ST_DIV1;
        end
        ST_DIV1: begin
          if (div_done) begin
            mean_r <= div_q[DW-1:0];
            state  <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (sq_done) begin
            if (sq_root > max_dev) begin
              max_dev <= sq_root;
            end
            if (more_x) begin
              cxo   <= cxo + XW'(1);
              wbase <= wbase + AW'(1);
              state <= ST_CINIT;
            end else if (more_y) begin
              cyo    <= cyo + YW'(1);
              cxo    <= '0;
              rstart <= rstart + AW'(sw);
              wbase  <= rstart + AW'(sw);
              state  <= ST_CINIT;
            end else begin
              rd_idx <= '0;
              rx     <= '0;
              ry     <= '0;
              state  <= ST_READ;
            end
          end
        end
        ST_READ: begin
          if (accept && (cmd.func == lab_pkg::FUNC_READ)) begin
            // A read past a shrunk frame is taken as its final pixel.
            if (rd_idx >= size) begin
              rd_idx <= size - (AW+1)'(1);
              rx     <= w - XW'(1);
              ry     <= h - YW'(1);
            end
            state <= ST_RD1;
          end
        end
        ST_RD1: begin
          last_r <= (rd_idx + (AW+1)'(1)) >= size;
          state  <= ST_RD2;
        end
        ST_RD2: begin
          state <= ST_RWAIT;
        end
        ST_RWAIT: begin
          if (thr_done) begin
            if (last_r) begin
              ld_idx  <= '0;
              rd_idx  <= '0;
              rx      <= '0;
              ry      <= '0;
              max_dev <= '0;
              min_pix <= lab_pkg::GRAY_MAX;
              state   <= ST_LOAD;
            end else begin
              rd_idx <= rd_idx + (AW+1)'(1);
              if ((32'(rx) + 32'd1) >= 32'(w)) begin
                rx <= '0;
                ry <= ry + YW'(1);
              end else begin
                rx <= rx + XW'(1);
              end
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Each read waits in ST_RWAIT for its strobe before the next is taken, so two result beats never touch.
  `ASSERT_NEXT(a_single_strobe, clk, rst, done, !done)
  // The final pixel of a frame returns the block to loading from the start.
  `ASSERT_NEXT(a_last_restarts, clk, rst, done && result.last, (state == ST_LOAD) && (ld_idx == '0))
  // The window walk stays inside the latched window.
  `ASSERT_IMPL(a_walk_bounds, clk, rst, state == ST_WIN, (wx < sww) && (wy < swh))

endmodule

@@ rtl/lab_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module lab_divider #(
  parameter int DVD_W = 52,
  parameter int DVS_W = 20,
  parameter int Q_W   = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [Q_W-1:0]   quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W-1:0] rem_nx;
  logic [CW-1:0]    cnt;
  logic             run;
  logic             ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh = {rem, dvd[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs};
    rem_nx = ge ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        dvd <= dividend;
        dvs <= divisor;
        rem <= '0;
        cnt <= '0;
      end else if (run) begin
        dvd      <= dvd << 1;
        rem      <= rem_nx;
        quotient <= {quotient[Q_W-2:0], ge};
        cnt      <= cnt + CW'(1);
        if (cnt == CW'(DVD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/lab_isqrt.sv @@
// Bitwise integer square root, one result bit per cycle.
module lab_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lab_pkg::RAD_W-1:0]    radicand,
  output logic                         done,
  output logic [lab_pkg::RAD_W/2-1:0]  root
);

  localparam int RW = lab_pkg::RAD_W;

  logic [RW-1:0] x;
  logic [RW-1:0] r;
  logic [RW-1:0] bitv;
  logic [RW:0]   trial;
  logic [RW-1:0] r_nx;
  logic [RW-1:0] x_nx;
  logic          run;
  logic          ge;

  // Trial subtraction of the current root estimate plus the probe bit.
  always_comb begin
    trial = (RW+1)'(r) + (RW+1)'(bitv);
    ge    = {1'b0, x} >= trial;
    r_nx  = ge ? (r >> 1) + bitv : r >> 1;
    x_nx  = ge ? x - RW'(trial) : x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        x    <= radicand;
        r    <= '0;
        bitv <= RW'(1) << (RW - 2);
      end else if (run) begin
        x    <= x_nx;
        r    <= r_nx;
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          run  <= 1'b0;
          done <= 1'b1;
          root <= r_nx[RW/2-1:0];
        end
      end
    end
  end

endmodule

@@ rtl/lab_thresh.sv @@
// Three-stage threshold compare for Niblack, Sauvola and Wolf-Jolion rules.
module lab_thresh (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  lab_pkg::lab_thr_req_t           req,
  input  logic [7:0]                      pix,
  input  logic [lab_pkg::DEV_W-1:0]       mean,
  input  logic [lab_pkg::DEV_W-1:0]       dev,
  output logic                            done,
  output logic                            white
);

  logic               is_nib;
  logic               is_wolf;
  logic [15:0]        d;
  logic [15:0]        pmul;
  logic signed [17:0] sd;
  logic signed [33:0] t1;
  logic [23:0]        pd;
  logic [31:0]        mx;
  logic signed [17:0] mdiff;

  logic               s1_v, s1_nib, s1_wolf, s1_fw, s1_fb;
  logic signed [33:0] s1_t1;
  logic signed [57:0] s1_lhs;
  logic [31:0]        s1_mx;
  logic signed [17:0] s1_mdiff;
  logic [15:0]        s1_mean;
  logic [15:0]        s1_rq;

  logic signed [35:0] a;
  logic signed [17:0] b;
  logic signed [57:0] c;
  logic signed [53:0] prod;

  logic               s2_v, s2_fw, s2_fb;
  logic signed [53:0] s2_prod;
  logic signed [57:0] s2_c;
  logic signed [57:0] s2_lhs;
  logic signed [57:0] rhs;

  // Stage one: deviation offset times gain, scaled pixel, mean products.
  always_comb begin
    is_nib  = req.mode == lab_pkg::MODE_NIBLACK;
    is_wolf = req.mode == lab_pkg::MODE_WOLF;
    d       = is_nib ? 16'd0 : (is_wolf ? req.max_dev : req.range_q);
    pmul    = is_nib ? 16'd1 : d;
    sd      = $signed({2'b00, dev}) - $signed({2'b00, d});
    t1      = 34'($signed(req.k_gain)) * 34'(sd);
    pd      = 24'(pix) * 24'(pmul);
    mx      = 32'(mean) * 32'(req.max_dev);
    mdiff   = $signed({2'b00, mean}) - $signed({2'b00, req.min_pixel, 8'h00});
  end

  // Stage two operands: the right side is a*b + c for every rule.
  always_comb begin
    if (!s1_nib && !s1_wolf) begin
      a = 36'(s1_t1) + $signed({8'b0, s1_rq, 12'b0});
    end else begin
      a = 36'(s1_t1);
    end
    if (s1_nib) begin
      b = 18'sd1;
      c = $signed({30'b0, s1_mean, 12'b0});
    end else if (s1_wolf) begin
      b = s1_mdiff;
      c = $signed({14'b0, s1_mx, 12'b0});
    end else begin
      b = $signed({2'b00, s1_mean});
      c = '0;
    end
    prod = a * b;
    rhs  = 58'(s2_prod) + s2_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_v <= start;
      s2_v <= s1_v;
      done <= s2_v;
    end
    s1_nib   <= is_nib;
    s1_wolf  <= is_wolf;
    s1_fw    <= req.force_white;
    s1_fb    <= req.force_black;
    s1_t1    <= t1;
    s1_lhs   <= $signed({14'b0, pd, 20'b0});
    s1_mx    <= mx;
    s1_mdiff <= mdiff;
    s1_mean  <= mean;
    s1_rq    <= req.range_q;
    s2_prod  <= prod;
    s2_c     <= c;
    s2_lhs   <= s1_lhs;
    s2_fw    <= s1_fw;
    s2_fb    <= s1_fb;
    white    <= s2_fw || (!s2_fb && (s2_lhs >= rhs));
  end

endmodule
